@@ rtl/ps2_mouse_packet_cursor_tracker_macros.svh @@
// Assertion helpers used by the tracker RTL.
`ifndef PS2_MOUSE_PACKET_CURSOR_TRACKER_MACROS_SVH
`define PS2_MOUSE_PACKET_CURSOR_TRACKER_MACROS_SVH

// Same-cycle implication, masked while reset is high.
`define PS2MCT_ASSERT(lbl, clk, rst, cond, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// Next-cycle implication, masked while reset is high.
`define PS2MCT_ASSERT_NEXT(lbl, clk, rst, cond, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

@@ rtl/ps2mct_pkg.sv @@
package ps2mct_pkg;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;

   localparam logic [CSR_IDX_W-1:0] CSR_COLUMNS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS    = 2'd1;

   localparam logic [CSR_DATA_W-1:0] RESET_COLUMNS = 9'd80;
   localparam logic [CSR_DATA_W-1:0] RESET_ROWS    = 9'd25;
   localparam logic [7:0]            RESET_POS_X   = 8'd40;
   localparam logic [7:0]            RESET_POS_Y   = 8'd12;

   // controller status bits
   localparam int STAT_READY_BIT = 0;
   localparam int STAT_AUX_BIT   = 5;

   // packet header bits
   localparam int HDR_LEFT_BIT  = 0;
   localparam int HDR_RIGHT_BIT = 1;
   localparam int HDR_SYNC_BIT  = 3;
   localparam int HDR_XSIGN_BIT = 4;
   localparam int HDR_YSIGN_BIT = 5;

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_DX     = 2'd1,
      PH_DY     = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      ST_ACCEPTED    = 2'd0,
      ST_NOT_READY   = 2'd1,
      ST_NOT_AUX     = 2'd2,
      ST_OUT_OF_SYNC = 2'd3
   } byte_status_type;

   typedef struct packed {
      phase_type  phase;
      logic [7:0] header;
      logic [7:0] dx_byte;
      logic       left;
      logic       right;
   } pkt_state_type;

   typedef struct packed {
      byte_status_type byte_status;
      logic            packet_done;
      logic [7:0]      cursor_x;
      logic [7:0]      cursor_y;
      logic            left_pressed;
      logic            right_pressed;
   } rsp_word_type;

endpackage

@@ rtl/ps2mct_req_if.sv @@
interface ps2mct_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] status_byte;
   logic [7:0] data_byte;

   modport source (output valid, output status_byte, output data_byte, input ready);
   modport sink (input valid, input status_byte, input data_byte, output ready);
endinterface

@@ rtl/ps2mct_rsp_if.sv @@
interface ps2mct_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] byte_status;
   logic       packet_done;
   logic [7:0] cursor_x;
   logic [7:0] cursor_y;
   logic       left_pressed;
   logic       right_pressed;

   modport source (
      output valid, output byte_status, output packet_done, output cursor_x,
      output cursor_y, output left_pressed, output right_pressed, input ready
   );
   modport sink (
      input valid, input byte_status, input packet_done, input cursor_x,
      input cursor_y, input left_pressed, input right_pressed, output ready
   );
endinterface

@@ rtl/ps2_mouse_packet_cursor_tracker.sv @@
// Path: an accepted word loads the input register, then the result register, from
// which the response channel takes it; a stall can hold the word in between.
// Throughput: one word per cycle unless the response side stalls; the packet state
// updates once per word as it moves from the input to the result register.
// Reset (synchronous, active high): both stages empty, phase at header, cursor at
// 40/12, buttons released, screen 80 columns by 25 rows.
`include "ps2_mouse_packet_cursor_tracker_macros.svh"

module ps2_mouse_packet_cursor_tracker #(
   parameter int COORD_WIDTH = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   ps2mct_req_if.sink                           req_chan,
   ps2mct_rsp_if.source                         rsp_chan,
   input  logic                                 csr_wr_en,
   input  logic [ps2mct_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ps2mct_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   // positions never exceed 255, so storage stops at 8 bits
   localparam int POS_W = (COORD_WIDTH > 8) ? 8 : COORD_WIDTH;

   logic [ps2mct_pkg::CSR_DATA_W-1:0] cols_ff;
   logic [ps2mct_pkg::CSR_DATA_W-1:0] rows_ff;

   logic       s1_valid_ff;
   logic [7:0] s1_status_ff;
   logic [7:0] s1_data_ff;

   ps2mct_pkg::pkt_state_type state_ff;
   ps2mct_pkg::pkt_state_type state_in;
   logic [POS_W-1:0]          pos_x_ff;
   logic [POS_W-1:0]          pos_y_ff;
   logic [POS_W-1:0]          pos_x_in;
   logic [POS_W-1:0]          pos_y_in;

   logic                      rsp_valid_ff;
   ps2mct_pkg::rsp_word_type  rsp_word_ff;
   ps2mct_pkg::rsp_word_type  rsp_word_in;

   logic s2_ready;
   logic s1_fire;

   assign s2_ready       = !rsp_valid_ff || rsp_chan.ready;
   assign s1_fire        = s1_valid_ff && s2_ready;
   assign req_chan.ready = !s1_valid_ff || s2_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= ps2mct_pkg::RESET_COLUMNS;
         rows_ff <= ps2mct_pkg::RESET_ROWS;
      end else if (csr_wr_en) begin
         if (csr_index == ps2mct_pkg::CSR_COLUMNS) cols_ff <= csr_wdata;
         else if (csr_index == ps2mct_pkg::CSR_ROWS) rows_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         s1_status_ff <= req_chan.status_byte;
         s1_data_ff   <= req_chan.data_byte;
      end
   end

   ps2mct_step #(
      .POS_W (POS_W)
   ) u_step (
      .status_byte (s1_status_ff),
      .data_byte   (s1_data_ff),
      .cur_state   (state_ff),
      .cur_pos_x   (pos_x_ff),
      .cur_pos_y   (pos_y_ff),
      .columns     (cols_ff),
      .rows        (rows_ff),
      .nxt_state   (state_in),
      .nxt_pos_x   (pos_x_in),
      .nxt_pos_y   (pos_y_in),
      .rsp_word    (rsp_word_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase   <= ps2mct_pkg::PH_HEADER;
         state_ff.header  <= 8'd0;
         state_ff.dx_byte <= 8'd0;
         state_ff.left    <= 1'b0;
         state_ff.right   <= 1'b0;
         pos_x_ff         <= POS_W'(ps2mct_pkg::RESET_POS_X);
         pos_y_ff         <= POS_W'(ps2mct_pkg::RESET_POS_Y);
      end else if (s1_fire) begin
         state_ff <= state_in;
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) rsp_word_ff <= rsp_word_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.byte_status   = rsp_word_ff.byte_status;
   assign rsp_chan.packet_done   = rsp_word_ff.packet_done;
   assign rsp_chan.cursor_x      = rsp_word_ff.cursor_x;
   assign rsp_chan.cursor_y      = rsp_word_ff.cursor_y;
   assign rsp_chan.left_pressed  = rsp_word_ff.left_pressed;
   assign rsp_chan.right_pressed = rsp_word_ff.right_pressed;

   // a parked word in the input register must not change under a stall
   `PS2MCT_ASSERT_NEXT(a_s1_hold, clock, reset, s1_valid_ff && !s2_ready,
      s1_valid_ff && $stable(s1_status_ff) && $stable(s1_data_ff),
      "input register changed while stalled")

   // completing a packet returns to the header phase and flags the result
   `PS2MCT_ASSERT_NEXT(a_done_phase, clock, reset, s1_fire && rsp_word_in.packet_done,
      state_ff.phase == ps2mct_pkg::PH_HEADER && rsp_valid_ff && rsp_word_ff.packet_done,
      "packet completion out of step with phase")

   // the result just loaded reports the position it left behind
   `PS2MCT_ASSERT_NEXT(a_cursor_track, clock, reset, s1_fire,
      rsp_valid_ff && rsp_word_ff.cursor_x == 8'(pos_x_ff)
         && rsp_word_ff.cursor_y == 8'(pos_y_ff),
      "reported cursor differs from held position")

endmodule

@@ rtl/ps2mct_step.sv @@
module ps2mct_step #(
   parameter int POS_W = 8
) (
   input  logic [7:0]                              status_byte,
   input  logic [7:0]                              data_byte,
   input  ps2mct_pkg::pkt_state_type               cur_state,
   input  logic [POS_W-1:0]                        cur_pos_x,
   input  logic [POS_W-1:0]                        cur_pos_y,
   input  logic [ps2mct_pkg::CSR_DATA_W-1:0]       columns,
   input  logic [ps2mct_pkg::CSR_DATA_W-1:0]       rows,
   output ps2mct_pkg::pkt_state_type               nxt_state,
   output logic [POS_W-1:0]                        nxt_pos_x,
   output logic [POS_W-1:0]                        nxt_pos_y,
   output ps2mct_pkg::rsp_word_type                rsp_word
);

   localparam logic [7:0] CAP = 8'((1 << POS_W) - 1);

   // dim 0 acts as 1, above 256 as 256; limit is dim - 1 capped to the coordinate range
   function automatic logic [7:0] grid_limit(input logic [ps2mct_pkg::CSR_DATA_W-1:0] dim);
      logic [ps2mct_pkg::CSR_DATA_W-1:0] d;
      logic [7:0]                        lim;
      d = dim;
      if (d == 9'd0) d = 9'd1;
      if (d > 9'd256) d = 9'd256;
      lim = 8'(d - 9'd1);
      if (lim > CAP) lim = CAP;
      return lim;
   endfunction

   function automatic logic [POS_W-1:0] clamp_pos(input logic signed [10:0] v,
                                                  input logic [7:0] lim);
      logic [POS_W-1:0] r;
      if (v < 0) r = '0;
      else if (v > $signed(11'(lim))) r = POS_W'(lim);
      else r = POS_W'(v);
      return r;
   endfunction

   logic              byte_ok;
   logic signed [10:0] dx_s;
   logic signed [10:0] dy_s;
   logic signed [10:0] sum_x;
   logic signed [10:0] sum_y;
   ps2mct_pkg::phase_type phase_in;
   ps2mct_pkg::byte_status_type code;
   logic              done;

   assign byte_ok = status_byte[ps2mct_pkg::STAT_READY_BIT]
                 && status_byte[ps2mct_pkg::STAT_AUX_BIT];

   assign dx_s  = 11'($signed({cur_state.header[ps2mct_pkg::HDR_XSIGN_BIT],
                                cur_state.dx_byte}));
   assign dy_s  = 11'($signed({cur_state.header[ps2mct_pkg::HDR_YSIGN_BIT], data_byte}));
   assign sum_x = $signed(11'(cur_pos_x)) + dx_s;
   assign sum_y = $signed(11'(cur_pos_y)) - dy_s;

   // next phase
   always_comb begin
      phase_in = cur_state.phase;
      if (byte_ok) begin
         case (cur_state.phase)
            ps2mct_pkg::PH_DX: phase_in = ps2mct_pkg::PH_DY;
            ps2mct_pkg::PH_DY: phase_in = ps2mct_pkg::PH_HEADER;
            default: begin
               phase_in = data_byte[ps2mct_pkg::HDR_SYNC_BIT] ? ps2mct_pkg::PH_DX
                                                              : ps2mct_pkg::PH_HEADER;
            end
         endcase
      end
   end

   // datapath and status
   always_comb begin
      nxt_state       = cur_state;
      nxt_state.phase = phase_in;
      nxt_pos_x       = cur_pos_x;
      nxt_pos_y       = cur_pos_y;
      code            = ps2mct_pkg::ST_ACCEPTED;
      done            = 1'b0;
      if (!status_byte[ps2mct_pkg::STAT_READY_BIT]) begin
         code = ps2mct_pkg::ST_NOT_READY;
      end else if (!status_byte[ps2mct_pkg::STAT_AUX_BIT]) begin
         code = ps2mct_pkg::ST_NOT_AUX;
      end else begin
         case (cur_state.phase)
            ps2mct_pkg::PH_DX: begin
               nxt_state.dx_byte = data_byte;
            end
            ps2mct_pkg::PH_DY: begin
               nxt_pos_x       = clamp_pos(sum_x, grid_limit(columns));
               nxt_pos_y       = clamp_pos(sum_y, grid_limit(rows));
               nxt_state.left  = cur_state.header[ps2mct_pkg::HDR_LEFT_BIT];
               nxt_state.right = cur_state.header[ps2mct_pkg::HDR_RIGHT_BIT];
               done            = 1'b1;
            end
            default: begin
               if (data_byte[ps2mct_pkg::HDR_SYNC_BIT]) nxt_state.header = data_byte;
               else code = ps2mct_pkg::ST_OUT_OF_SYNC;
            end
         endcase
      end
   end

   assign rsp_word.byte_status   = code;
   assign rsp_word.packet_done   = done;
   assign rsp_word.cursor_x      = 8'(nxt_pos_x);
   assign rsp_word.cursor_y      = 8'(nxt_pos_y);
   assign rsp_word.left_pressed  = nxt_state.left;
   assign rsp_word.right_pressed = nxt_state.right;

endmodule

@@ tb/sv/ps2_mouse_packet_cursor_tracker_tb.sv @@
`timescale 1ns / 1ps

// Tracks packet phase, cursor and buttons; holds the expected response words in order.
class cursor_scoreboard;
   localparam int COORD_W   = 8;
   localparam int COORD_CAP = (1 << COORD_W) - 1;

   ps2mct_pkg::phase_type        phase;
   logic [7:0]                   header;
   logic [7:0]                   dx_byte;
   logic [7:0]                   pos_x;
   logic [7:0]                   pos_y;
   logic                         left_btn;
   logic                         right_btn;
   logic [8:0]                   columns;
   logic [8:0]                   rows;
   ps2mct_pkg::rsp_word_type     expected_words[$];
   int                           error_count;
   int                           word_count;
   int                           packet_count;
   int                           taken_count;

   function new();
      phase        = ps2mct_pkg::PH_HEADER;
      header       = '0;
      dx_byte      = '0;
      pos_x        = ps2mct_pkg::RESET_POS_X;
      pos_y        = ps2mct_pkg::RESET_POS_Y;
      left_btn     = 1'b0;
      right_btn    = 1'b0;
      columns      = ps2mct_pkg::RESET_COLUMNS;
      rows         = ps2mct_pkg::RESET_ROWS;
      error_count  = 0;
      word_count   = 0;
      packet_count = 0;
      taken_count  = 0;
   endfunction

   function void set_dim(logic [ps2mct_pkg::CSR_IDX_W-1:0] idx,
                         logic [ps2mct_pkg::CSR_DATA_W-1:0] val);
      if (idx == ps2mct_pkg::CSR_COLUMNS) columns = val;
      else if (idx == ps2mct_pkg::CSR_ROWS) rows = val;
   endfunction

   // zero acts as one, anything past 256 as 256
   function int grid_limit(logic [8:0] dim);
      int lim;
      lim = int'(dim);
      if (lim < 1) lim = 1;
      if (lim > 256) lim = 256;
      lim = lim - 1;
      if (lim > COORD_CAP) lim = COORD_CAP;
      return lim;
   endfunction

   function logic [7:0] clamp_coord(int v, int lim);
      if (v < 0) return 8'd0;
      if (v > lim) return lim[7:0];
      return v[7:0];
   endfunction

   function void note_byte(logic [7:0] st, logic [7:0] db);
      ps2mct_pkg::rsp_word_type w;
      int dx;
      int dy;
      w.byte_status = ps2mct_pkg::ST_ACCEPTED;
      w.packet_done = 1'b0;
      if (!st[ps2mct_pkg::STAT_READY_BIT]) begin
         w.byte_status = ps2mct_pkg::ST_NOT_READY;
      end else if (!st[ps2mct_pkg::STAT_AUX_BIT]) begin
         w.byte_status = ps2mct_pkg::ST_NOT_AUX;
      end else begin
         taken_count++;
         case (phase)
            ps2mct_pkg::PH_DX: begin
               dx_byte = db;
               phase   = ps2mct_pkg::PH_DY;
            end
            ps2mct_pkg::PH_DY: begin
               dx = int'(dx_byte);
               dy = int'(db);
               if (header[ps2mct_pkg::HDR_XSIGN_BIT]) dx = dx - 256;
               if (header[ps2mct_pkg::HDR_YSIGN_BIT]) dy = dy - 256;
               pos_x     = clamp_coord(int'(pos_x) + dx, grid_limit(columns));
               pos_y     = clamp_coord(int'(pos_y) - dy, grid_limit(rows));
               left_btn  = header[ps2mct_pkg::HDR_LEFT_BIT];
               right_btn = header[ps2mct_pkg::HDR_RIGHT_BIT];
               phase     = ps2mct_pkg::PH_HEADER;
               w.packet_done = 1'b1;
               packet_count++;
            end
            default: begin
               if (db[ps2mct_pkg::HDR_SYNC_BIT]) begin
                  header = db;
                  phase  = ps2mct_pkg::PH_DX;
               end else begin
                  w.byte_status = ps2mct_pkg::ST_OUT_OF_SYNC;
                  phase = ps2mct_pkg::PH_HEADER;
               end
            end
         endcase
      end
      w.cursor_x      = pos_x;
      w.cursor_y      = pos_y;
      w.left_pressed  = left_btn;
      w.right_pressed = right_btn;
      expected_words.push_back(w);
   endfunction

   task report_mismatch(string msg);
      error_count++;
      $display("MISMATCH %s", msg);
   endtask

   task check_word(ps2mct_pkg::rsp_word_type got);
      ps2mct_pkg::rsp_word_type want;
      string diffs;
      word_count++;
      if (expected_words.size() == 0) begin
         report_mismatch($sformatf("word %0d arrived with nothing expected (%h)",
                                   word_count, got));
         return;
      end
      want  = expected_words.pop_front();
      diffs = "";
      if (got.byte_status !== want.byte_status)
         diffs = {diffs, $sformatf(" status %0d/%0d", got.byte_status, want.byte_status)};
      if (got.packet_done !== want.packet_done)
         diffs = {diffs, $sformatf(" done %b/%b", got.packet_done, want.packet_done)};
      if (got.cursor_x !== want.cursor_x)
         diffs = {diffs, $sformatf(" x %0d/%0d", got.cursor_x, want.cursor_x)};
      if (got.cursor_y !== want.cursor_y)
         diffs = {diffs, $sformatf(" y %0d/%0d", got.cursor_y, want.cursor_y)};
      if (got.left_pressed !== want.left_pressed)
         diffs = {diffs, $sformatf(" left %b/%b", got.left_pressed, want.left_pressed)};
      if (got.right_pressed !== want.right_pressed)
         diffs = {diffs, $sformatf(" right %b/%b", got.right_pressed, want.right_pressed)};
      if (diffs != "") report_mismatch($sformatf("word %0d got/exp:%s", word_count, diffs));
   endtask
endclass

module ps2_mouse_packet_cursor_tracker_tb;
   localparam int CYCLE_LIMIT      = 400000;
   localparam int RANDOM_PER_PHASE = 190;
   localparam int NUM_PHASES       = 9;
   localparam logic [ps2mct_pkg::CSR_IDX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [ps2mct_pkg::CSR_IDX_W-1:0] CSR_SPARE_HI = 2'd3;

   logic                                clock = 1'b0;
   logic                                reset;
   logic                                csr_wr_en;
   logic [ps2mct_pkg::CSR_IDX_W-1:0]    csr_index;
   logic [ps2mct_pkg::CSR_DATA_W-1:0]   csr_wdata;
   int                                  send_idle_pct;
   int                                  recv_idle_pct;
   cursor_scoreboard                    sb = new();

   ps2mct_req_if req ();
   ps2mct_rsp_if rsp ();

   ps2_mouse_packet_cursor_tracker #(.COORD_WIDTH(8)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req),
      .rsp_chan  (rsp),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Simulation FAILED");
      $finish;
   end

   initial begin : response_sink
      ps2mct_pkg::rsp_word_type got;
      rsp.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp.valid && rsp.ready) begin
            got.byte_status   = ps2mct_pkg::byte_status_type'(rsp.byte_status);
            got.packet_done   = rsp.packet_done;
            got.cursor_x      = rsp.cursor_x;
            got.cursor_y      = rsp.cursor_y;
            got.left_pressed  = rsp.left_pressed;
            got.right_pressed = rsp.right_pressed;
            sb.check_word(got);
         end
         rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic send_byte(logic [7:0] st, logic [7:0] db);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid       <= 1'b1;
      req.status_byte <= st;
      req.data_byte   <= db;
      do @(posedge clock); while (!req.ready);
      sb.note_byte(st, db);
   endtask

   function automatic logic [7:0] taken_status();
      logic [7:0] st;
      st = 8'($urandom);
      st[ps2mct_pkg::STAT_READY_BIT] = 1'b1;
      st[ps2mct_pkg::STAT_AUX_BIT]   = 1'b1;
      return st;
   endfunction

   function automatic logic [7:0] ignored_status();
      logic [7:0] st;
      st = 8'($urandom);
      if ($urandom_range(1)) begin
         st[ps2mct_pkg::STAT_READY_BIT] = 1'b0;
      end else begin
         st[ps2mct_pkg::STAT_READY_BIT] = 1'b1;
         st[ps2mct_pkg::STAT_AUX_BIT]   = 1'b0;
      end
      return st;
   endfunction

   task automatic maybe_noise();
      if ($urandom_range(9) == 0) send_byte(ignored_status(), 8'($urandom));
   endtask

   // small deltas keep the cursor roaming mid-screen, raw bytes slam it to the edges
   task automatic send_packet();
      logic [7:0] hdr;
      logic [7:0] dx;
      logic [7:0] dy;
      int         step;
      hdr = 8'($urandom);
      hdr[ps2mct_pkg::HDR_SYNC_BIT] = 1'b1;
      if ($urandom_range(1)) begin
         step = int'($urandom_range(16)) - 8;
         dx   = step[7:0];
         step = int'($urandom_range(16)) - 8;
         dy   = step[7:0];
         hdr[ps2mct_pkg::HDR_XSIGN_BIT] = dx[7];
         hdr[ps2mct_pkg::HDR_YSIGN_BIT] = dy[7];
      end else begin
         dx = 8'($urandom);
         dy = 8'($urandom);
      end
      send_byte(taken_status(), hdr);
      maybe_noise();
      send_byte(taken_status(), dx);
      maybe_noise();
      send_byte(taken_status(), dy);
   endtask

   task automatic run_random(int count);
      int target;
      int pick;
      target = sb.taken_count + count;
      while (sb.taken_count < target) begin
         pick = $urandom_range(99);
         if (pick < 80) send_packet();
         else if (pick < 92) send_byte(taken_status(), 8'($urandom));
         else send_byte(ignored_status(), 8'($urandom));
      end
   endtask

   task automatic run_directed();
      logic [7:0] dir_status[21] = '{
         8'h00, 8'h20, 8'hDF, 8'h21, 8'hFF,
         8'h21, 8'h21, 8'h21,
         8'hFF, 8'hFF, 8'hFF,
         8'h21, 8'h21, 8'h21,
         8'h21, 8'h21, 8'h21,
         8'h21, 8'h00, 8'h21, 8'h01};
      logic [7:0] dir_data[21] = '{
         8'hFF, 8'hFF, 8'h08, 8'h00, 8'hF7,
         8'h08, 8'h7F, 8'h00,
         8'h38, 8'h80, 8'h80,
         8'hCB, 8'h00, 8'hFF,
         8'hFF, 8'hFF, 8'hFF,
         8'h0C, 8'h55, 8'h01, 8'h00};
      foreach (dir_status[i]) send_byte(dir_status[i], dir_data[i]);
      // finish the packet left open by the interleaved ignored bytes
      send_byte(8'h21, 8'hFE);
   endtask

   task automatic drain_results();
      req.valid <= 1'b0;
      while (sb.expected_words.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic [ps2mct_pkg::CSR_IDX_W-1:0] idx,
                            logic [ps2mct_pkg::CSR_DATA_W-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.set_dim(idx, val);
      @(posedge clock);
   endtask

   initial begin : stimulus
      int col_set[NUM_PHASES]  = '{80, 256, 1, 0, 511, 200, 2, 256, 80};
      int row_set[NUM_PHASES]  = '{25, 256, 1, 0, 300, 60, 256, 3, 25};
      reset           <= 1'b1;
      req.valid       <= 1'b0;
      req.status_byte <= '0;
      req.data_byte   <= '0;
      csr_wr_en       <= 1'b0;
      csr_index       <= '0;
      csr_wdata       <= '0;
      send_idle_pct = 21;
      recv_idle_pct = 54;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();
      for (int p = 0; p < NUM_PHASES; p++) begin
         if (p == 3) begin
            send_idle_pct = 54;
            recv_idle_pct = 21;
         end else if (p == 6) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         drain_results();
         write_csr(ps2mct_pkg::CSR_COLUMNS, col_set[p][ps2mct_pkg::CSR_DATA_W-1:0]);
         write_csr(ps2mct_pkg::CSR_ROWS, row_set[p][ps2mct_pkg::CSR_DATA_W-1:0]);
         // unmapped indexes must leave the screen size alone
         if (p == 5) begin
            write_csr(CSR_SPARE_LO, 9'h1FF);
            write_csr(CSR_SPARE_HI, 9'h000);
         end
         run_random(RANDOM_PER_PHASE);
      end
      drain_results();
      repeat (8) @(posedge clock);

      $display("Checked %0d words: %0d bytes taken, %0d packets, %0d screen sizes",
               sb.word_count, sb.taken_count, sb.packet_count, NUM_PHASES);
      $display("Sizes spanned zero, one, 256 and oversized; %0d mismatches",
               sb.error_count);
      if (sb.error_count == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end
endmodule

@@ files.f @@
+incdir+rtl
rtl/ps2mct_pkg.sv
rtl/ps2mct_req_if.sv
rtl/ps2mct_rsp_if.sv
rtl/ps2mct_step.sv
rtl/ps2_mouse_packet_cursor_tracker.sv
tb/sv/ps2_mouse_packet_cursor_tracker_tb.sv
